@@ sv/mcdg_pkg.sv @@
// ----------------------------------------------------------------------------
// mcdg_pkg
// Shared types and constants for the masked central difference gradient block.
// ----------------------------------------------------------------------------
package mcdg_pkg;

  localparam int PIX_W      = 16;
  localparam int GRAD_W     = 17;
  localparam int ENERGY_W   = 33;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_ADDR_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_FRAME_WIDTH  = cfg_index_t'(0);
  localparam cfg_index_t CFG_FRAME_HEIGHT = cfg_index_t'(1);

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(480);

  // one line buffer word: newest line, line before it, mask of newest line
  typedef struct packed {
    logic [PIX_W-1:0] row0;
    logic [PIX_W-1:0] row1;
    logic             mask;
  } line_word_t;

  // differences of one window, ahead of the squaring stage
  typedef struct packed {
    logic signed [GRAD_W-1:0] dx;
    logic signed [GRAD_W-1:0] dy;
    logic                     last;
  } grad_t;

endpackage

@@ sv/mcdg_if.sv @@
// ----------------------------------------------------------------------------
// mcdg_if
// Valid/ready channels of the gradient block: pixels, results, configuration.
// ----------------------------------------------------------------------------
interface mcdg_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [mcdg_pkg::PIX_W-1:0]  pixel_value;
  logic                        masked;
  logic                        drain;

  modport source (output valid, pixel_value, masked, drain, input ready);
  modport sink   (input valid, pixel_value, masked, drain, output ready);
endinterface

interface mcdg_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [mcdg_pkg::GRAD_W-1:0]  grad_x;
  logic signed [mcdg_pkg::GRAD_W-1:0]  grad_y;
  logic [mcdg_pkg::ENERGY_W-1:0]       grad_energy;
  logic                                frame_last;

  modport source (output valid, grad_x, grad_y, grad_energy, frame_last, input ready);
  modport sink   (input valid, grad_x, grad_y, grad_energy, frame_last, output ready);
endinterface

interface mcdg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mcdg_pkg::CFG_ADDR_W-1:0]  index;
  logic [mcdg_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/mcdg_line_buffer.sv @@
// ----------------------------------------------------------------------------
// mcdg_line_buffer
// Two line delays of pixels plus one of mask bits, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module mcdg_line_buffer #(
  parameter int DEPTH = 2048
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  mcdg_pkg::line_word_t       wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output mcdg_pkg::line_word_t       rdata
);

  mcdg_pkg::line_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/mcdg_energy.sv @@
// ----------------------------------------------------------------------------
// mcdg_energy
// Squares and sums the differences and holds the result register.
// ----------------------------------------------------------------------------
module mcdg_energy (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  grad_valid,
  input  mcdg_pkg::grad_t       grad,
  output logic                  grad_ready,
  mcdg_result_if.source         results
);

  logic signed [2*mcdg_pkg::GRAD_W-1:0] sq_x;
  logic signed [2*mcdg_pkg::GRAD_W-1:0] sq_y;
  logic [mcdg_pkg::ENERGY_W-1:0]        energy_next;

  assign sq_x        = grad.dx * grad.dx;
  assign sq_y        = grad.dy * grad.dy;
  assign energy_next = mcdg_pkg::ENERGY_W'($unsigned(sq_x))
                     + mcdg_pkg::ENERGY_W'($unsigned(sq_y));

  assign grad_ready = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (grad_ready) begin
      results.valid <= grad_valid;
    end
    if (grad_ready && grad_valid) begin
      results.grad_x      <= grad.dx;
      results.grad_y      <= grad.dy;
      results.grad_energy <= energy_next;
      results.frame_last  <= grad.last;
    end
  end

endmodule

@@ sv/masked_central_difference_gradient_top.sv @@
// ----------------------------------------------------------------------------
// masked_central_difference_gradient_top
// Central difference gradient over a raster pixel stream with a mask bit,
// two line delays, border and mask zeroing, squared magnitude.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                    request
//  pixels    in    pixel_value, masked, drain                 one pixel or drain item
//  results   out   grad_x, grad_y, grad_energy, frame_last     one gradient result
//  cfg       in    index, data                                one register write
//
//  one request per cycle sustained while results are taken; the request that
//  completes a window passes it to the difference register, then the result register
//  the rate is set by the line buffer: one write and one prefetched read per cycle
//  rst clears counters, frame size, window registers and valid flags; the data
//  registers and the line buffer are not cleared, no clearing pass
//  a stalled result holds; one further request is taken into the difference
//  register before pixels.ready drops
// ----------------------------------------------------------------------------
module masked_central_difference_gradient_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic          clk,
  input  logic          rst,
  mcdg_pixel_if.sink    pixels,
  mcdg_result_if.source results,
  mcdg_cfg_if.sink      cfg
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 3);
  localparam int CMPW  = (mcdg_pkg::FW_W > WW) ? mcdg_pkg::FW_W : WW;
  localparam int CMPH  = (mcdg_pkg::FH_W > RW) ? mcdg_pkg::FH_W : RW;
  localparam int PW    = mcdg_pkg::PIX_W;

  logic [mcdg_pkg::FW_W-1:0] frame_width;
  logic [mcdg_pkg::FH_W-1:0] frame_height;

  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;

  logic [PW-1:0] win_center, win_left, win_below, above_pix;
  logic          mask_c;

  mcdg_pkg::line_word_t taps, wword;

  logic            s1v;
  mcdg_pkg::grad_t s1, grad_next;
  logic            e_ready;

  logic pix_acc, cfg_acc, cfg_hit;

  // clamped frame size
  logic [CMPW-1:0] fw_ext;
  logic [CMPH-1:0] fh_ext;
  logic [WW-1:0]   w_eff, wm1;
  logic [RW-1:0]   h_eff;

  always_comb begin
    fw_ext = CMPW'(frame_width);
    fh_ext = CMPH'(frame_height);
    priority if (fw_ext < CMPW'(3)) begin
      w_eff = WW'(3);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_ext);
    end
    priority if (fh_ext < CMPH'(3)) begin
      h_eff = RW'(3);
    end else if (fh_ext > CMPH'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(fh_ext);
    end
    wm1 = w_eff - WW'(1);
  end

  // window position and result flags
  logic [WW-1:0] col_ext;
  logic          col_zero, res_valid, border, last;
  logic [PW-1:0] x_in;
  logic          m_in;

  always_comb begin
    col_ext  = WW'(col);
    col_zero = (col == '0);
    if (!col_zero) begin
      res_valid = (row >= RW'(1)) && (row <= h_eff);
      border    = (row == RW'(1)) || (row == h_eff) || (col == CW'(1));
      last      = 1'b0;
    end else begin
      res_valid = (row >= RW'(2)) && (row <= h_eff + RW'(1));
      border    = 1'b1;
      last      = (row == h_eff + RW'(1));
    end
    x_in = pixels.drain ? '0 : pixels.pixel_value;
    m_in = pixels.drain ? 1'b0 : pixels.masked;
  end

  always_comb begin
    grad_next.last = last;
    if (border || mask_c) begin
      grad_next.dx = '0;
      grad_next.dy = '0;
    end else begin
      grad_next.dx = $signed({1'b0, taps.row0}) - $signed({1'b0, win_left});
      grad_next.dy = $signed({1'b0, win_below}) - $signed({1'b0, above_pix});
    end
  end

  // handshakes
  assign pixels.ready = !s1v || e_ready;
  assign cfg.ready    = 1'b1;
  assign pix_acc      = pixels.valid && pixels.ready;
  assign cfg_acc      = cfg.valid && cfg.ready;
  assign cfg_hit      = cfg_acc && ((cfg.index == mcdg_pkg::CFG_FRAME_WIDTH) ||
                                    (cfg.index == mcdg_pkg::CFG_FRAME_HEIGHT));

  // stream position
  always_comb begin
    col_next = col;
    row_next = row;
    priority if (rst || cfg_hit) begin
      col_next = '0;
      row_next = '0;
    end else if (pix_acc) begin
      priority if (last) begin
        col_next = '0;
        row_next = '0;
      end else if (col_ext == wm1) begin
        col_next = '0;
        if (row < h_eff + RW'(2)) begin
          row_next = row + RW'(1);
        end
      end else begin
        col_next = col + CW'(1);
      end
    end else begin
      col_next = col;
    end
  end

  assign wword = '{row0: x_in, row1: taps.row0, mask: m_in};

  mcdg_line_buffer #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buffer (
    .clk   (clk),
    .we    (pix_acc),
    .waddr (col),
    .wdata (wword),
    .raddr (col_next),
    .rdata (taps)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= mcdg_pkg::FRAME_WIDTH_RESET;
      frame_height <= mcdg_pkg::FRAME_HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
      win_center   <= '0;
      win_left     <= '0;
      win_below    <= '0;
      above_pix    <= '0;
      mask_c       <= 1'b0;
      s1v          <= 1'b0;
    end else begin
      col <= col_next;
      row <= row_next;
      if (cfg_acc) begin
        unique case (cfg.index)
          mcdg_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg.data[mcdg_pkg::FW_W-1:0];
          mcdg_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg.data[mcdg_pkg::FH_W-1:0];
          default: ;
        endcase
      end
      if (pix_acc) begin
        win_left   <= win_center;
        win_center <= taps.row0;
        win_below  <= x_in;
        above_pix  <= taps.row1;
        mask_c     <= taps.mask;
      end
      if (pixels.ready) begin
        s1v <= pix_acc && res_valid;
      end
    end
    if (pix_acc && res_valid) begin
      s1 <= grad_next;
    end
  end

  mcdg_energy u_energy (
    .clk        (clk),
    .rst        (rst),
    .grad_valid (s1v),
    .grad       (s1),
    .grad_ready (e_ready),
    .results    (results)
  );

  // checks
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    col_ext < w_eff)
    else $error("column position beyond frame width");

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    pix_acc && !last && (col_ext != wm1) && !cfg_hit |=> col == $past(col) + CW'(1))
    else $error("column position did not advance");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row <= h_eff + RW'(2))
    else $error("row position past saturation");

  a_last_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.frame_last |-> results.grad_energy == '0)
    else $error("frame corner result not zeroed");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1v && !e_ready |=> s1v && (s1 == $past(s1)))
    else $error("difference register lost a stalled result");

endmodule
